/* rtl/trp_pkg.sv */
`timescale 1ns / 1ps

package trp_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned GUARD_BITS = 8;
  localparam int unsigned VEC_W = DIFF_W + GUARD_BITS + 3;
  localparam int unsigned ANG_W = 34;
  localparam int unsigned HEAD_W = 16;
  localparam int unsigned PROD_W = VEC_W + 16;
  localparam int unsigned RND_W = PROD_W - 16 - GUARD_BITS;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ATAN_ENTRIES = 32;

  localparam logic [15:0] INV_GAIN_HI = 16'h9B74;
  localparam logic [15:0] INV_GAIN_LO = 16'hEDA8;

  localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1,
    CFG_HEADING  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } trp_vec_t;

  function automatic logic [ANG_W-1:0] trp_atan(input int unsigned idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return ANG_W'(v);
  endfunction

endpackage

/* rtl/trp_front.sv */
`timescale 1ns / 1ps

module trp_front import trp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] origin_x,
  input  logic signed [COORD_W-1:0] origin_y,
  input  logic        [HEAD_W-1:0]  heading,
  output logic                      out_valid,
  input  logic                      out_ready,
  output trp_vec_t                  out_vec
);

  logic                     v1_r;
  logic signed [DIFF_W-1:0] dx_r;
  logic signed [DIFF_W-1:0] dy_r;
  quad_t                    q_r;
  logic signed [ANG_W-1:0]  z_r;
  logic                     v2_r;
  trp_vec_t                 vec_r;

  logic                     rdy1;
  logic                     rdy2;
  logic [HEAD_W-1:0]        head_bias;
  logic [1:0]               q_nxt;
  logic [HEAD_W-1:0]        resid;
  logic signed [DIFF_W-1:0] dx_nxt;
  logic signed [DIFF_W-1:0] dy_nxt;
  logic signed [VEC_W-1:0]  xe;
  logic signed [VEC_W-1:0]  ye;
  trp_vec_t                 vec_nxt;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign head_bias = heading + HEAD_W'(16'h2000);
  assign q_nxt     = head_bias[HEAD_W-1:HEAD_W-2];
  assign resid     = heading - {q_nxt, {(HEAD_W-2){1'b0}}};
  assign dx_nxt    = DIFF_W'(point_x) - DIFF_W'(origin_x);
  assign dy_nxt    = DIFF_W'(point_y) - DIFF_W'(origin_y);

  assign xe = VEC_W'(dx_r) <<< GUARD_BITS;
  assign ye = VEC_W'(dy_r) <<< GUARD_BITS;

  always_comb begin
    vec_nxt.z = z_r;
    unique case (q_r)
      QUAD_0: begin
        vec_nxt.x = xe;
        vec_nxt.y = ye;
      end
      QUAD_90: begin
        vec_nxt.x = -ye;
        vec_nxt.y = xe;
      end
      QUAD_180: begin
        vec_nxt.x = -xe;
        vec_nxt.y = -ye;
      end
      QUAD_270: begin
        vec_nxt.x = ye;
        vec_nxt.y = -xe;
      end
      default: begin
        vec_nxt.x = xe;
        vec_nxt.y = ye;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      q_r  <= quad_t'(q_nxt);
      z_r  <= {{(ANG_W-HEAD_W-16){resid[HEAD_W-1]}}, resid, 16'h0000};
    end
    if (v1_r && rdy2) vec_r <= vec_nxt;
  end

  assign out_valid = v2_r;
  assign out_vec   = vec_r;

endmodule

/* rtl/trp_cell.sv */
`timescale 1ns / 1ps

module trp_cell import trp_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  trp_vec_t in_vec,
  output logic     out_valid,
  input  logic     out_ready,
  output trp_vec_t out_vec
);

  localparam logic [ANG_W-1:0] ATAN = trp_atan(SHIFT);

  logic                    vld_r;
  trp_vec_t                vec_r;
  logic signed [VEC_W-1:0] xs;
  logic signed [VEC_W-1:0] ys;
  trp_vec_t                vec_nxt;

  assign in_ready = !vld_r || out_ready;

  assign xs = $signed(in_vec.x) >>> SHIFT;
  assign ys = $signed(in_vec.y) >>> SHIFT;

  always_comb begin
    if (!in_vec.z[ANG_W-1]) begin
      vec_nxt.x = in_vec.x - ys;
      vec_nxt.y = in_vec.y + xs;
      vec_nxt.z = in_vec.z - $signed(ATAN);
    end else begin
      vec_nxt.x = in_vec.x + ys;
      vec_nxt.y = in_vec.y - xs;
      vec_nxt.z = in_vec.z + $signed(ATAN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) vec_r <= vec_nxt;
  end

  assign out_valid = vld_r;
  assign out_vec   = vec_r;

endmodule

/* rtl/trp_gain.sv */
`timescale 1ns / 1ps

module trp_gain import trp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  trp_vec_t                  in_vec,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] view_x,
  output logic signed [COORD_W-1:0] view_y,
  output logic                      clipped
);

  logic                     v1_r;
  logic                     v2_r;
  logic                     v3_r;
  logic                     v4_r;
  logic [1:0]               neg1_r;
  logic [1:0]               neg2_r;
  logic [1:0]               neg3_r;
  logic [VEC_W-1:0]         mag_r [2];
  logic [PROD_W-1:0]        phi_r [2];
  logic [PROD_W-1:0]        plo_r [2];
  logic [RND_W-1:0]         rnd_r [2];
  logic signed [COORD_W-1:0] res_r [2];
  logic                     clip_r;

  logic                     rdy1;
  logic                     rdy2;
  logic                     rdy3;
  logic                     rdy4;
  logic signed [VEC_W-1:0]  ax [2];
  logic [VEC_W-1:0]         mag_nxt [2];
  logic [PROD_W-1:0]        sum [2];
  logic [PROD_W-1:0]        sum_rnd [2];
  logic signed [COORD_W-1:0] res_nxt [2];
  logic [1:0]               clip_nxt;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign ax[0] = in_vec.x;
  assign ax[1] = in_vec.y;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      mag_nxt[k] = ax[k][VEC_W-1] ? VEC_W'(-ax[k]) : VEC_W'(ax[k]);
      sum[k]     = phi_r[k] + (plo_r[k] >> 16);
      sum_rnd[k] = sum[k] + (PROD_W'(1) << (15 + GUARD_BITS));
      if (!neg3_r[k] && (rnd_r[k] > RND_W'(SAT_MAX))) begin
        res_nxt[k]  = SAT_MAX;
        clip_nxt[k] = 1'b1;
      end else if (neg3_r[k] && (rnd_r[k] > RND_W'({1'b0, SAT_MIN}))) begin
        res_nxt[k]  = SAT_MIN;
        clip_nxt[k] = 1'b1;
      end else begin
        res_nxt[k]  = neg3_r[k] ? -$signed(rnd_r[k][COORD_W-1:0])
                                : $signed(rnd_r[k][COORD_W-1:0]);
        clip_nxt[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      neg1_r <= {ax[1][VEC_W-1], ax[0][VEC_W-1]};
      for (int k = 0; k < 2; k++) mag_r[k] <= mag_nxt[k];
    end
    if (v1_r && rdy2) begin
      neg2_r <= neg1_r;
      for (int k = 0; k < 2; k++) begin
        phi_r[k] <= PROD_W'(mag_r[k]) * PROD_W'(INV_GAIN_HI);
        plo_r[k] <= PROD_W'(mag_r[k]) * PROD_W'(INV_GAIN_LO);
      end
    end
    if (v2_r && rdy3) begin
      neg3_r <= neg2_r;
      for (int k = 0; k < 2; k++) rnd_r[k] <= sum_rnd[k][PROD_W-1:16+GUARD_BITS];
    end
    if (v3_r && rdy4) begin
      for (int k = 0; k < 2; k++) res_r[k] <= res_nxt[k];
      clip_r <= |clip_nxt;
    end
  end

  assign out_valid = v4_r;
  assign view_x    = res_r[0];
  assign view_y    = res_r[1];
  assign clipped   = clip_r;

endmodule

/* rtl/translate_rotate_point_2d_top.sv */
// Translate-and-rotate of 2D points into a viewer frame (CORDIC rotation).
// Input channel (in_valid/in_ready): one request carries a world point
// (in_point_x, in_point_y), signed with 8 fraction bits. The block subtracts
// the origin, rotates by the heading and returns out_view_x/out_view_y plus
// out_clipped when a coordinate saturated to the 32-bit range.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 origin x,
// 1 origin y, 2 heading (low 16 bits, 65536 = full turn); index 3 is ignored.
// cfg_ready is always high; write only while no request is in flight.
// Pipeline: two register stages of subtract and quadrant pre-rotation, one per
// micro-rotation cell, four of magnitude, gain multiply, rounding, saturation.
// Throughput: one request per cycle unless stalled; one point per register.
// Stall: when out_ready is low the result holds on the outputs, bubbles
// in the cell chain still fill, and in_ready drops once every stage is full.
// Reset (rst_n low, synchronous) empties the pipeline and clears the origin
// and heading to zero.
`timescale 1ns / 1ps

module translate_rotate_point_2d_top import trp_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_view_x,
  output logic signed [COORD_W-1:0] out_view_y,
  output logic                      out_clipped,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [COORD_W-1:0]        cfg_data
);

  logic signed [COORD_W-1:0] origin_x_r;
  logic signed [COORD_W-1:0] origin_y_r;
  logic [HEAD_W-1:0]         heading_r;

  logic     chain_valid [CORDIC_STAGES+1];
  logic     chain_ready [CORDIC_STAGES+1];
  trp_vec_t chain_vec   [CORDIC_STAGES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      heading_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: origin_x_r <= $signed(cfg_data);
        CFG_ORIGIN_Y: origin_y_r <= $signed(cfg_data);
        CFG_HEADING:  heading_r  <= cfg_data[HEAD_W-1:0];
        default: ;
      endcase
    end
  end

  trp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .point_x   (in_point_x),
    .point_y   (in_point_y),
    .origin_x  (origin_x_r),
    .origin_y  (origin_y_r),
    .heading   (heading_r),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_vec   (chain_vec[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    trp_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_vec    (chain_vec[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_vec   (chain_vec[i+1])
    );
  end

  trp_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[CORDIC_STAGES]),
    .in_ready  (chain_ready[CORDIC_STAGES]),
    .in_vec    (chain_vec[CORDIC_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .view_x    (out_view_x),
    .view_y    (out_view_y),
    .clipped   (out_clipped)
  );

`ifndef ASSERT_OFF
  a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      (out_view_x == SAT_MAX || out_view_x == SAT_MIN ||
       out_view_y == SAT_MAX || out_view_y == SAT_MIN))
    else $error("clipped result not at a saturation bound");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output register empty");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      (out_valid && $stable(out_view_x) && $stable(out_view_y) &&
       $stable(out_clipped)))
    else $error("stalled result changed before it was taken");
`endif

endmodule

/* sim/translate_rotate_point_2d_top_tb.sv */
`timescale 1ns / 1ps

module translate_rotate_point_2d_top_tb;
  import trp_pkg::*;

  localparam int unsigned ROT_STEPS = 16;
  localparam int unsigned GUARD = 8;
  localparam longint unsigned GAIN_HI = 64'h9B74;
  localparam longint unsigned GAIN_LO = 64'hEDA8;
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam longint unsigned ATAN_TAB [0:15] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef struct {
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic                      clip;
  } view_t;

  class view_scoreboard;
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
    logic [15:0]               heading;
    view_t                     views_q[$];
    int                        mismatches;
    int                        checked;
    int                        clipped_seen;

    function new();
      org_x = '0;
      org_y = '0;
      heading = '0;
      mismatches = 0;
      checked = 0;
      clipped_seen = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [COORD_W-1:0] data);
      case (idx)
        CFG_ORIGIN_X: org_x = data;
        CFG_ORIGIN_Y: org_y = data;
        CFG_HEADING:  heading = data[15:0];
        default: ;
      endcase
    endfunction

    // 1/K gain on the magnitude, round half away from zero
    function longint gain_fix(longint v);
      longint unsigned m;
      longint unsigned s;
      longint unsigned r;
      m = (v < 0) ? longint'(-v) : longint'(v);
      s = m * GAIN_HI + ((m * GAIN_LO) >> 16);
      r = (s + (64'd1 << (15 + GUARD))) >> (16 + GUARD);
      return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function logic signed [COORD_W-1:0] clamp(longint v, inout bit clip);
      if (v > longint'(C_MAX)) begin
        clip = 1'b1;
        return C_MAX;
      end
      if (v < longint'(C_MIN)) begin
        clip = 1'b1;
        return C_MIN;
      end
      return v[COORD_W-1:0];
    endfunction

    function void note_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
      longint x;
      longint y;
      longint t;
      longint z;
      longint xs;
      longint ys;
      logic [15:0] hq;
      logic [15:0] resid;
      quad_t quad;
      bit clip;
      view_t v;
      x = (longint'(px) - longint'(org_x)) * (64'sd1 <<< GUARD);
      y = (longint'(py) - longint'(org_y)) * (64'sd1 <<< GUARD);
      hq = heading + 16'h2000;
      quad = quad_t'(hq[15:14]);
      resid = heading - {quad, 14'b0};
      z = longint'($signed(resid)) * 65536;
      case (quad)
        QUAD_90: begin
          t = x;
          x = -y;
          y = t;
        end
        QUAD_180: begin
          x = -x;
          y = -y;
        end
        QUAD_270: begin
          t = x;
          x = y;
          y = -t;
        end
        default: ;
      endcase
      for (int i = 0; i < ROT_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(ATAN_TAB[i]);
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(ATAN_TAB[i]);
        end
      end
      clip = 1'b0;
      v.vx = clamp(gain_fix(x), clip);
      v.vy = clamp(gain_fix(y), clip);
      v.clip = clip;
      views_q = {views_q, v};
    endfunction

    function void check_view(logic signed [COORD_W-1:0] vx, logic signed [COORD_W-1:0] vy,
                             logic clip);
      view_t e;
      if (views_q.size() == 0) begin
        $error("unexpected result: view_x %0d view_y %0d clipped %0b", vx, vy, clip);
        mismatches++;
        return;
      end
      e = views_q.pop_front();
      checked++;
      if (clip) clipped_seen++;
      if (vx !== e.vx) begin
        $error("view_x mismatch: expected %0d, got %0d", e.vx, vx);
        mismatches++;
      end
      if (vy !== e.vy) begin
        $error("view_y mismatch: expected %0d, got %0d", e.vy, vy);
        mismatches++;
      end
      if (clip !== e.clip) begin
        $error("clipped mismatch: expected %0b, got %0b", e.clip, clip);
        mismatches++;
      end
    endfunction

    function int pending();
      return views_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b1;
  logic signed [COORD_W-1:0] out_view_x;
  logic signed [COORD_W-1:0] out_view_y;
  logic                      out_clipped;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = '0;
  logic [COORD_W-1:0]        cfg_data = '0;

  int gap_pct = 0;
  int stall_pct = 0;
  int settings_cnt = 0;

  view_scoreboard sb = new();

  translate_rotate_point_2d_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_view_x (out_view_x),
    .out_view_y (out_view_y),
    .out_clipped(out_clipped),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_point(in_point_x, in_point_y);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_view(out_view_x, out_view_y, out_clipped);
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // pipeline must be empty; the unused index write must change nothing
  task automatic apply_setting(input logic signed [COORD_W-1:0] ox,
                               input logic signed [COORD_W-1:0] oy,
                               input logic [15:0] hd);
    cfg_write(CFG_ORIGIN_X, ox);
    cfg_write(CFG_ORIGIN_Y, oy);
    cfg_write(CFG_HEADING, {16'($urandom_range(0, 65535)), hd});
    cfg_write(CFG_UNUSED_IDX, $urandom);
    cfg_valid <= 1'b0;
    settings_cnt++;
  endtask

  task automatic send_point(input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] base);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      8: return C_MAX;
      9: return C_MIN;
      default: return base + $urandom_range(0, 2097152) - 1048576;
    endcase
  endfunction

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [15:0] bound_heads [7] = '{16'h1FFF, 16'h2000, 16'h4000, 16'h6000,
                                     16'hA000, 16'hDFFF, 16'hE000};
    int gap_mode [4] = '{0, 51, 0, 24};
    int stall_mode [4] = '{0, 0, 51, 24};
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic [15:0] hd;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero origin, zero heading
    send_point(0, 0);
    send_point(C_MAX, C_MAX);
    send_point(C_MIN, C_MIN);
    send_point(C_MAX, C_MIN);
    send_point(C_MIN, C_MAX);
    send_point(256, 0);
    send_point(0, -256);
    drain();

    // extreme origins, widest differences, saturation
    apply_setting(C_MIN, C_MAX, 16'hFFFF);
    send_point(C_MAX, C_MIN);
    send_point(C_MIN, C_MAX);
    send_point(0, 0);
    send_point(C_MIN, C_MIN);
    drain();
    apply_setting(C_MAX, C_MIN, 16'h8000);
    send_point(C_MIN, C_MAX);
    send_point(C_MAX, C_MIN);
    send_point(0, 0);
    drain();

    // quadrant boundaries of the heading
    foreach (bound_heads[k]) begin
      apply_setting(1000, -1000, bound_heads[k]);
      send_point(5000, 3000);
      drain();
    end

    for (int p = 0; p < 8; p++) begin
      ox = (p == 0) ? '0 : pick_coord(0);
      oy = (p == 0) ? '0 : pick_coord(0);
      hd = (p == 4) ? 16'hFFFF : (p == 6) ? 16'h0000 : 16'($urandom);
      apply_setting(ox, oy, hd);
      gap_pct = gap_mode[p % 4];
      stall_pct = stall_mode[p % 4];
      for (int n = 0; n < 125; n++) begin
        send_point(pick_coord(ox), pick_coord(oy));
      end
      drain();
    end

    gap_pct = 0;
    stall_pct = 0;
    repeat (40) @(posedge clk);

    $display("%0d points checked over %0d register settings and four idle patterns",
             sb.checked, settings_cnt);
    $display("%0d results saturated, %0d mismatches", sb.clipped_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
